@@ hw/rtl/slkv_pkg.sv @@
// ----------------------------------------------------------------------------
// slkv_pkg: shared types and codes for the skip-list key/value store
// Request codes, result status codes and the level LFSR constants.
// ----------------------------------------------------------------------------
`default_nettype none
package slkv_pkg;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam int unsigned LFSR_BITS = 16;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'h0001;

  // one Galois step of the level LFSR
  function automatic logic [15:0] lfsr_step(input logic [15:0] x);
    lfsr_step = x[0] ? ((x >> 1) ^ LFSR_TAPS) : (x >> 1);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/slkv_ram.sv @@
// ----------------------------------------------------------------------------
// slkv_ram: generic single-port synchronous RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module slkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/skip_list_key_value_store.sv @@
// ----------------------------------------------------------------------------
// skip_list_key_value_store: sorted key/value map held as a skip list
// Lookup, insert and remove over a fixed node pool kept in on-chip RAMs.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown on value_out/status for a single cycle with done high. The
// receiver cannot stall it. One request is in flight at a time. The search
// walks from the top level down, one key compare at a time. A compare
// fetches the link, waits on the link RAM read unless the current node is
// the head, reads the key, waits on the key RAM unless the link points at
// the tail, and compares. A walk makes MAX_LEVELS + (nodes stepped)
// compares. After the walk come the hit read, the decision and the result.
// An insert that takes a node adds the free-stack pop and, per level of the
// new node, a write of its link and one of the predecessor's link. A remove
// that hits adds the push and, per level over all MAX_LEVELS, a read of the
// hit node's link and, where the hit node sits at that level, an update of
// the predecessor's link. After reset a clearing pass fills the free stack
// while busy stays high.
// Node links live in one RAM addressed node*MAX_LEVELS + level; head links,
// preds and succs per level are small flop arrays. A link value of
// POOL_NODES is tail.
// ----------------------------------------------------------------------------
`default_nettype none
module skip_list_key_value_store #(
  parameter int POOL_NODES = 1024,
  parameter int MAX_LEVELS = 10,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            req_type,
  input  wire logic [KEY_BITS-1:0]   key,
  input  wire logic [VALUE_BITS-1:0] value_in,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      value_out,
  output logic [1:0]                 status
);

  localparam int NB = $clog2(POOL_NODES);     // node index bits
  localparam int LB = NB + 1;                  // link bits (tail = POOL_NODES)
  localparam int VB = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int HB = $clog2(MAX_LEVELS + 1);  // height bits
  localparam int LINK_DEPTH = POOL_NODES * MAX_LEVELS;
  localparam int AB = $clog2(LINK_DEPTH);
  localparam int CB = $clog2(POOL_NODES + 1);
  localparam logic [LB-1:0] TAIL = LB'(POOL_NODES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LVL, S_LNK_WAIT, S_KEY_RD, S_KEY_WAIT, S_KEY_CMP,
    S_HIT_RD, S_HIT_WAIT, S_DECIDE, S_WRITE, S_FREE_RD, S_FREE_WAIT,
    S_RM_RD, S_RM_WAIT, S_RESP
  } state_t;

  state_t state;

  // request registers
  logic [1:0]            req;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;

  // walk state
  logic [VB-1:0] lvl;
  logic          cur_head;          // current node is the head sentinel
  logic [NB-1:0] cur;
  logic [LB-1:0] nxt;
  logic          pred_head [MAX_LEVELS];
  logic [NB-1:0] pred      [MAX_LEVELS];
  logic [LB-1:0] succ      [MAX_LEVELS];
  logic [LB-1:0] head_link [MAX_LEVELS];
  logic          found;
  logic [NB-1:0] newn;
  logic [HB-1:0] height;
  logic [CB-1:0] free_count;
  logic [15:0]   lfsr;
  logic [NB-1:0] clr_idx;
  logic [VALUE_BITS-1:0] hit_val;

  // RAM ports
  logic                  k_we, v_we, l_we, f_we;
  logic [NB-1:0]         k_addr, v_addr, f_addr;
  logic [AB-1:0]         l_addr;
  logic [KEY_BITS-1:0]   k_rd;
  logic [VALUE_BITS-1:0] v_rd;
  logic [LB-1:0]         l_wd, l_rd;
  logic [NB-1:0]         f_wd, f_rd;

  slkv_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_NODES)) u_keys (
    .clk, .we(k_we), .addr(k_addr), .wdata(rkey), .rdata(k_rd));
  slkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_vals (
    .clk, .we(v_we), .addr(v_addr), .wdata(rval), .rdata(v_rd));
  slkv_ram #(.WIDTH(LB), .DEPTH(LINK_DEPTH)) u_links (
    .clk, .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));
  slkv_ram #(.WIDTH(NB), .DEPTH(POOL_NODES)) u_free (
    .clk, .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));

  function automatic logic [AB-1:0] laddr(input logic [NB-1:0] n, input logic [VB-1:0] l);
    laddr = AB'(32'(n) * MAX_LEVELS + 32'(l));
  endfunction

  // write-phase level counter shares lvl; link of the hit node is read at lvl
  logic [LB-1:0] clamp_rd;
  assign clamp_rd = (l_rd < TAIL) ? l_rd : TAIL;

  // height from LFSR: 1 + trailing ones of the advanced value, capped
  logic [15:0] lfsr_adv;
  logic [HB-1:0] new_height;
  assign lfsr_adv = slkv_pkg::lfsr_step(lfsr);
  always_comb begin
    new_height = HB'(1);
    for (int i = 0; i < MAX_LEVELS - 1; i++) begin
      if (i < 16 && 32'(new_height) == i + 1 && lfsr_adv[i % 16]) begin
        new_height = new_height + HB'(1);
      end
    end
  end

  logic lvl_is_top;
  assign lvl_is_top = (32'(lvl) == MAX_LEVELS - 1);

  // RAM address / write steering
  always_comb begin
    k_we = 1'b0; v_we = 1'b0; l_we = 1'b0; f_we = 1'b0;
    k_addr = nxt[NB-1:0];
    v_addr = succ[0][NB-1:0];
    l_addr = laddr(cur, lvl);
    l_wd = TAIL;
    // free_count is already decremented when the pop is read
    f_addr = NB'(free_count);
    f_wd = succ[0][NB-1:0];
    case (state)
      S_CLEAR: begin
        f_we = 1'b1; f_addr = clr_idx; f_wd = NB'(POOL_NODES - 1) - clr_idx;
      end
      S_HIT_RD: begin
        k_addr = succ[0][NB-1:0];
      end
      S_WRITE: begin
        if (req == slkv_pkg::REQ_INSERT) begin
          // write new node fields and its forward link at this level
          k_we = (lvl == '0); v_we = (lvl == '0);
          k_addr = newn; v_addr = newn;
          l_we = 1'b1; l_addr = laddr(newn, lvl); l_wd = succ[lvl];
          if (!pred_head[lvl]) begin
            // pred link written in the next cycle via S_RM_RD reuse
          end
        end else begin
          l_we = !pred_head[lvl] && succ[lvl] == {1'b0, succ[0][NB-1:0]};
          l_addr = laddr(pred[lvl], lvl); l_wd = nxt;
        end
      end
      S_RM_RD: begin
        if (req == slkv_pkg::REQ_INSERT) begin
          l_we = !pred_head[lvl]; l_addr = laddr(pred[lvl], lvl);
          l_wd = {1'b0, newn};
        end else begin
          l_addr = laddr(succ[0][NB-1:0], lvl);
        end
      end
      S_FREE_RD: begin
        if (req == slkv_pkg::REQ_REMOVE) begin
          f_we = 1'b1; f_addr = NB'(free_count);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      busy <= 1'b1;
      clr_idx <= '0;
      free_count <= CB'(POOL_NODES);
      lfsr <= slkv_pkg::LFSR_SEED;
      for (int i = 0; i < MAX_LEVELS; i++) head_link[i] <= TAIL;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + NB'(1);
          if (32'(clr_idx) == POOL_NODES - 1) begin
            state <= S_IDLE; busy <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            req <= req_type; rkey <= key; rval <= value_in;
            lvl <= VB'(MAX_LEVELS - 1);
            cur_head <= 1'b1;
            state <= S_LVL;
          end
        end
        S_LVL: begin
          // fetch link leaving cur at lvl
          if (cur_head) begin
            nxt <= head_link[lvl];
            state <= S_KEY_RD;
          end else begin
            state <= S_LNK_WAIT;
          end
        end
        S_LNK_WAIT: begin
          nxt <= clamp_rd;
          state <= S_KEY_RD;
        end
        S_KEY_RD: begin
          if (nxt == TAIL) begin
            state <= S_KEY_CMP;
          end else begin
            state <= S_KEY_WAIT;
          end
        end
        S_KEY_WAIT: state <= S_KEY_CMP;
        S_KEY_CMP: begin
          if (nxt != TAIL && k_rd < rkey) begin
            cur_head <= 1'b0; cur <= nxt[NB-1:0];
            state <= S_LVL;
          end else begin
            pred_head[lvl] <= cur_head; pred[lvl] <= cur; succ[lvl] <= nxt;
            if (lvl == '0) begin
              state <= S_HIT_RD;
            end else begin
              lvl <= lvl - VB'(1);
              state <= S_LVL;
            end
          end
        end
        S_HIT_RD: state <= S_HIT_WAIT;
        S_HIT_WAIT: begin
          found <= (succ[0] != TAIL) && (k_rd == rkey);
          hit_val <= v_rd;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          value_out <= '0;
          lvl <= '0;
          state <= S_RESP;
          if (req == slkv_pkg::REQ_INSERT) begin
            if (found) begin
              status <= slkv_pkg::ST_PRESENT;
            end else if (free_count == '0) begin
              status <= slkv_pkg::ST_FULL;
            end else begin
              status <= slkv_pkg::ST_DONE;
              lfsr <= lfsr_adv;
              height <= new_height;
              free_count <= free_count - CB'(1);
              state <= S_FREE_RD;
            end
          end else if (req == slkv_pkg::REQ_REMOVE) begin
            if (found) begin
              status <= slkv_pkg::ST_DONE;
              value_out <= hit_val;
              state <= S_FREE_RD;
            end else begin
              status <= slkv_pkg::ST_ABSENT;
            end
          end else begin
            status <= found ? slkv_pkg::ST_DONE : slkv_pkg::ST_ABSENT;
            value_out <= found ? hit_val : '0;
          end
        end
        S_FREE_RD: begin
          // insert pops (read), remove pushes (write)
          if (req == slkv_pkg::REQ_REMOVE) begin
            if (32'(free_count) < POOL_NODES) free_count <= free_count + CB'(1);
            state <= S_RM_RD;
          end else begin
            state <= S_FREE_WAIT;
          end
        end
        S_FREE_WAIT: begin
          newn <= f_rd;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (req == slkv_pkg::REQ_INSERT) begin
            if (pred_head[lvl]) head_link[lvl] <= {1'b0, newn};
            state <= S_RM_RD;
          end else begin
            if (pred_head[lvl] && succ[lvl] == {1'b0, succ[0][NB-1:0]}) begin
              head_link[lvl] <= nxt;
            end
            if (lvl_is_top) begin
              state <= S_RESP;
            end else begin
              lvl <= lvl + VB'(1);
              state <= S_RM_RD;
            end
          end
        end
        S_RM_RD: begin
          if (req == slkv_pkg::REQ_INSERT) begin
            if (32'(lvl) + 1 >= 32'(height)) begin
              state <= S_RESP;
            end else begin
              lvl <= lvl + VB'(1);
              state <= S_WRITE;
            end
          end else begin
            state <= S_RM_WAIT;
          end
        end
        S_RM_WAIT: begin
          nxt <= clamp_rd;
          state <= S_WRITE;
        end
        S_RESP: begin
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/slkv_checker.sv @@
// ----------------------------------------------------------------------------
// slkv_checker: port-level checks for the skip-list store
// One result per request, never while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module slkv_checker #(
  parameter int VALUE_BITS = 32
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done,
  input wire logic [VALUE_BITS-1:0] value_out,
  input wire logic [1:0]            status
);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without request");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != slkv_pkg::ST_DONE) |-> value_out == '0)
    else $error("nonzero value on failure");

endmodule

bind skip_list_key_value_store slkv_checker #(.VALUE_BITS(VALUE_BITS)) u_slkv_checker (
  .clk, .rst, .start, .busy, .done, .value_out, .status);
`default_nettype wire
